// File: design/qaar_pkg.sv
`timescale 1ns / 1ps
package qaar_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS = 31;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [32:0] RAD_TO_PHASE = 33'd2734261102;
  localparam logic [32:0] DEG_TO_PHASE = 33'd3054198966;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle;
    logic               angle_unit;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_axis;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               zero;
  } vec_side_t;

  typedef struct packed {
    vec_side_t        v;
    logic [2:0]       axis_neg;
    logic [2:0][31:0] axis_mag;
  } axis_side_t;

  typedef struct packed {
    logic [63:0]        sum;
    logic signed [33:0] z;
    logic               half_neg;
    axis_side_t         side;
  } rt_in_t;

  typedef struct packed {
    logic [31:0]        len;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic               half_neg;
    axis_side_t         side;
  } rt_out_t;

  typedef struct packed {
    vec_side_t          v;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } div_side_t;

  typedef struct packed {
    logic [31:0]      len;
    logic [2:0]       axis_neg;
    logic [2:0][31:0] axis_mag;
    div_side_t        side;
  } div_in_t;

  typedef struct packed {
    logic [2:0]       axis_neg;
    logic [2:0][30:0] quot;
    div_side_t        side;
  } div_out_t;

  function automatic logic [29:0] atan_phase(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000029;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000003;
      5'd29: r = 30'h00000001;
      5'd30: r = 30'h00000001;
      default: r = 30'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: design/qaar_root_trig.sv
`timescale 1ns / 1ps
module qaar_root_trig import qaar_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  rt_in_t  in_data,
  output logic    out_valid,
  output rt_out_t out_data
);

  localparam int CORDIC_STEPS = (TRIG_ITERATIONS > ROOT_STEPS) ? ROOT_STEPS : TRIG_ITERATIONS;

  typedef struct packed {
    logic [63:0]        rem;
    logic [63:0]        root;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               half_neg;
    axis_side_t         side;
  } rt_stage_t;

  rt_stage_t               stage      [ROOT_STEPS];
  rt_stage_t               stage_next [ROOT_STEPS];
  logic [ROOT_STEPS-1:0]   vld;

  always_comb begin
    rt_stage_t          prev;
    logic [63:0]        bitv;
    logic [63:0]        trial;
    logic signed [33:0] atn;
    for (int i = 0; i < ROOT_STEPS; i++) begin
      if (i == 0) begin
        prev.rem      = in_data.sum;
        prev.root     = '0;
        prev.x        = CORDIC_GAIN;
        prev.y        = '0;
        prev.z        = in_data.z;
        prev.half_neg = in_data.half_neg;
        prev.side     = in_data.side;
      end else begin
        prev = stage[i-1];
      end
      stage_next[i] = prev;
      // one square root digit
      bitv  = 64'd1 << (62 - 2 * i);
      trial = prev.root + bitv;
      if (prev.rem >= trial) begin
        stage_next[i].rem  = prev.rem - trial;
        stage_next[i].root = (prev.root >> 1) + bitv;
      end else begin
        stage_next[i].root = prev.root >> 1;
      end
      // one cordic rotation, in the first CORDIC_STEPS stages only
      atn = $signed({4'b0000, atan_phase(5'(i))});
      if (i < CORDIC_STEPS) begin
        if (!prev.z[33]) begin
          stage_next[i].x = prev.x - (prev.y >>> i);
          stage_next[i].y = prev.y + (prev.x >>> i);
          stage_next[i].z = prev.z - atn;
        end else begin
          stage_next[i].x = prev.x + (prev.y >>> i);
          stage_next[i].y = prev.y - (prev.x >>> i);
          stage_next[i].z = prev.z + atn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

  assign out_valid         = vld[ROOT_STEPS-1];
  assign out_data.len      = stage[ROOT_STEPS-1].root[31:0];
  assign out_data.x        = stage[ROOT_STEPS-1].x;
  assign out_data.y        = stage[ROOT_STEPS-1].y;
  assign out_data.half_neg = stage[ROOT_STEPS-1].half_neg;
  assign out_data.side     = stage[ROOT_STEPS-1].side;

endmodule

// File: design/qaar_div.sv
`timescale 1ns / 1ps
module qaar_div import qaar_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  div_in_t  in_data,
  output logic     out_valid,
  output div_out_t out_data
);

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][30:0] quot;
    logic [2:0]       low_bit;
    logic [31:0]      len;
    logic [2:0]       axis_neg;
    div_side_t        side;
  } div_stage_t;

  div_stage_t           stage      [DIV_STEPS];
  div_stage_t           stage_next [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld;

  always_comb begin
    div_stage_t  prev;
    logic [32:0] trial;
    logic        inbit;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        for (int k = 0; k < 3; k++) begin
          prev.rem[k]     = {1'b0, in_data.axis_mag[k][31:1]};
          prev.low_bit[k] = in_data.axis_mag[k][0];
        end
        prev.quot     = '0;
        prev.len      = in_data.len;
        prev.axis_neg = in_data.axis_neg;
        prev.side     = in_data.side;
      end else begin
        prev = stage[j-1];
      end
      stage_next[j] = prev;
      for (int k = 0; k < 3; k++) begin
        inbit = (j == 0) ? prev.low_bit[k] : 1'b0;
        trial = {prev.rem[k], inbit};
        if (trial >= {1'b0, prev.len}) begin
          stage_next[j].rem[k]  = 32'(trial - {1'b0, prev.len});
          stage_next[j].quot[k] = {prev.quot[k][29:0], 1'b1};
        end else begin
          stage_next[j].rem[k]  = trial[31:0];
          stage_next[j].quot[k] = {prev.quot[k][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

  assign out_valid         = vld[DIV_STEPS-1];
  assign out_data.axis_neg = stage[DIV_STEPS-1].axis_neg;
  assign out_data.quot     = stage[DIV_STEPS-1].quot;
  assign out_data.side     = stage[DIV_STEPS-1].side;

endmodule

// File: design/quaternion_axis_angle_rotate_top.sv
`timescale 1ns / 1ps
// channel   signals                             payload
// item      item_valid / item_ready / item      item_t
// result    result_valid / result_ready / result  result_t
//
// one transaction accepted per cycle unless a held result stalls the pipeline
// the pipeline holds the 32 square root digit stages and the 31 divider stages
// rst clears only the stage valid bits
// a held result freezes the whole pipeline, item_ready drops with it
module quaternion_axis_angle_rotate_top import qaar_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) r = ONE_Q30;
    else if (v < -34'sd1073741824) r = -ONE_Q30;
    else r = 32'(v);
    return r;
  endfunction

  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // stage a: phase product, axis magnitudes
  logic                a_vld;
  item_t               a_item;
  logic [63:0]         a_prod, a_prod_next;
  logic [2:0][31:0]    a_mag, a_mag_next;
  logic [2:0]          a_neg, a_neg_next;
  logic [31:0]         a_max, a_max_next;
  logic                a_zero, a_zero_next;

  always_comb begin
    logic signed [65:0] prod_full;
    logic signed [31:0] ax [3];
    logic [31:0]        m01;
    ax[0] = item.axis_x;
    ax[1] = item.axis_y;
    ax[2] = item.axis_z;
    prod_full = item.angle * $signed({1'b0, item.angle_unit ? DEG_TO_PHASE : RAD_TO_PHASE});
    a_prod_next = prod_full[63:0];
    for (int k = 0; k < 3; k++) begin
      a_neg_next[k] = ax[k][31];
      a_mag_next[k] = ax[k][31] ? (~ax[k] + 32'd1) : ax[k];
    end
    m01 = (a_mag_next[0] > a_mag_next[1]) ? a_mag_next[0] : a_mag_next[1];
    a_max_next  = (m01 > a_mag_next[2]) ? m01 : a_mag_next[2];
    a_zero_next = (item.axis_x == '0) && (item.axis_y == '0) && (item.axis_z == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= item;
      a_prod <= a_prod_next;
      a_mag  <= a_mag_next;
      a_neg  <= a_neg_next;
      a_max  <= a_max_next;
      a_zero <= a_zero_next;
    end
  end

  // stage b: half angle, axis block scaling
  logic                b_vld;
  axis_side_t          b_side, b_side_next;
  logic signed [33:0]  b_z, b_z_next;
  logic                b_half_neg, b_half_neg_next;

  always_comb begin
    logic [31:0] phase;
    logic [30:0] half;
    logic [4:0]  msb;
    logic [4:0]  shamt;
    phase = a_item.angle_unit ? a_prod[55:24] : a_prod[49:18];
    half  = phase[31:1];
    b_half_neg_next = half[30];
    b_z_next = $signed({3'b000, half}) - (half[30] ? 34'sh80000000 : 34'sh0);
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (a_max[i]) msb = 5'(i);
    end
    shamt = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
    for (int k = 0; k < 3; k++) begin
      b_side_next.axis_mag[k] = a_mag[k] << shamt;
    end
    b_side_next.axis_neg = a_neg;
    b_side_next.v.vec_x  = a_item.vec_x;
    b_side_next.v.vec_y  = a_item.vec_y;
    b_side_next.v.vec_z  = a_item.vec_z;
    b_side_next.v.zero   = a_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side     <= b_side_next;
      b_z        <= b_z_next;
      b_half_neg <= b_half_neg_next;
    end
  end

  // stage c: squares
  logic                c_vld;
  logic [2:0][63:0]    c_sq, c_sq_next;
  axis_side_t          c_side;
  logic signed [33:0]  c_z;
  logic                c_half_neg;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_sq_next[k] = b_side.axis_mag[k] * b_side.axis_mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sq       <= c_sq_next;
      c_side     <= b_side;
      c_z        <= b_z;
      c_half_neg <= b_half_neg;
    end
  end

  // stage d: sum of squares
  logic    d_vld;
  rt_in_t  d_data;

  always_ff @(posedge clk) begin
    if (en) begin
      d_data.sum      <= c_sq[0] + c_sq[1] + c_sq[2];
      d_data.z        <= c_z;
      d_data.half_neg <= c_half_neg;
      d_data.side     <= c_side;
    end
  end

  logic    rt_vld;
  rt_out_t rt_out;

  qaar_root_trig #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_root_trig (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_vld),
    .in_data  (d_data),
    .out_valid(rt_vld),
    .out_data (rt_out)
  );

  // stage e: cosine and sine of the half angle
  logic    e_vld;
  div_in_t e_data, e_data_next;

  always_comb begin
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    xs = rt_out.half_neg ? -rt_out.x : rt_out.x;
    ys = rt_out.half_neg ? -rt_out.y : rt_out.y;
    e_data_next.len      = rt_out.len;
    e_data_next.axis_neg = rt_out.side.axis_neg;
    e_data_next.axis_mag = rt_out.side.axis_mag;
    e_data_next.side.v   = rt_out.side.v;
    e_data_next.side.c   = clamp_q30(xs);
    e_data_next.side.s   = clamp_q30(ys);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_data <= e_data_next;
    end
  end

  logic     dv_vld;
  div_out_t dv_out;

  qaar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (e_vld),
    .in_data  (e_data),
    .out_valid(dv_vld),
    .out_data (dv_out)
  );

  // stage f: signed unit axis
  logic                     f_vld;
  logic signed [2:0][31:0]  f_u, f_u_next;
  div_side_t                f_side;

  always_comb begin
    logic [31:0] q;
    for (int k = 0; k < 3; k++) begin
      q = {1'b0, dv_out.quot[k]};
      if (q > 32'h40000000) q = 32'h40000000;
      f_u_next[k] = dv_out.axis_neg[k] ? -$signed(q) : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_u    <= f_u_next;
      f_side <= dv_out.side;
    end
  end

  // stage g: sin times unit axis
  logic                     g_vld;
  logic signed [63:0]       g_prod [3];
  div_side_t                g_side;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g_prod[k] <= f_side.s * $signed(f_u[k]);
      end
      g_side <= f_side;
    end
  end

  // stage h: quaternion parts
  logic                h_vld;
  logic signed [31:0]  h_q [4];
  vec_side_t           h_v;

  always_ff @(posedge clk) begin
    logic signed [63:0] rs;
    if (en) begin
      h_q[0] <= g_side.c;
      for (int k = 0; k < 3; k++) begin
        rs = g_prod[k] + 64'sd536870912;
        h_q[k+1] <= $signed(rs[61:30]);
      end
      h_v <= g_side.v;
    end
  end

  // stage i: first product terms
  logic                i_vld;
  logic signed [63:0]  i_p [12];
  logic signed [31:0]  i_q [4];
  vec_side_t           i_v;

  always_ff @(posedge clk) begin
    if (en) begin
      i_p[0]  <= h_q[1] * h_v.vec_x;
      i_p[1]  <= h_q[2] * h_v.vec_y;
      i_p[2]  <= h_q[3] * h_v.vec_z;
      i_p[3]  <= h_q[0] * h_v.vec_x;
      i_p[4]  <= h_q[2] * h_v.vec_z;
      i_p[5]  <= h_q[3] * h_v.vec_y;
      i_p[6]  <= h_q[0] * h_v.vec_y;
      i_p[7]  <= h_q[1] * h_v.vec_z;
      i_p[8]  <= h_q[3] * h_v.vec_x;
      i_p[9]  <= h_q[0] * h_v.vec_z;
      i_p[10] <= h_q[1] * h_v.vec_y;
      i_p[11] <= h_q[2] * h_v.vec_x;
      i_q     <= h_q;
      i_v     <= h_v;
    end
  end

  // stage j: q * v
  logic                j_vld;
  logic signed [33:0]  j_t [4];
  logic signed [31:0]  j_q [4];
  vec_side_t           j_v;

  always_ff @(posedge clk) begin
    logic signed [65:0] acc [4];
    if (en) begin
      acc[0] = -i_p[0] - i_p[1] - i_p[2] + 66'sd536870912;
      acc[1] = i_p[3] + i_p[4] - i_p[5] + 66'sd536870912;
      acc[2] = i_p[6] - i_p[7] + i_p[8] + 66'sd536870912;
      acc[3] = i_p[9] + i_p[10] - i_p[11] + 66'sd536870912;
      for (int k = 0; k < 4; k++) begin
        j_t[k] <= $signed(acc[k][63:30]);
      end
      j_q <= i_q;
      j_v <= i_v;
    end
  end

  // stage k: second product terms
  logic                k_vld;
  logic signed [65:0]  k_p [12];
  vec_side_t           k_v;

  always_ff @(posedge clk) begin
    if (en) begin
      k_p[0]  <= j_t[0] * j_q[1];
      k_p[1]  <= j_t[1] * j_q[0];
      k_p[2]  <= j_t[2] * j_q[3];
      k_p[3]  <= j_t[3] * j_q[2];
      k_p[4]  <= j_t[0] * j_q[2];
      k_p[5]  <= j_t[1] * j_q[3];
      k_p[6]  <= j_t[2] * j_q[0];
      k_p[7]  <= j_t[3] * j_q[1];
      k_p[8]  <= j_t[0] * j_q[3];
      k_p[9]  <= j_t[1] * j_q[2];
      k_p[10] <= j_t[2] * j_q[1];
      k_p[11] <= j_t[3] * j_q[0];
      k_v     <= j_v;
    end
  end

  // stage l: (q * v) * conj(q), round, saturate; a zero axis passes the vector through
  result_t l_data;

  always_comb begin
    logic signed [67:0] acc [3];
    logic signed [37:0] r;
    logic signed [31:0] o [3];
    logic               sat;
    acc[0] = -k_p[0] + k_p[1] - k_p[2] + k_p[3] + 68'sd536870912;
    acc[1] = -k_p[4] + k_p[5] + k_p[6] - k_p[7] + 68'sd536870912;
    acc[2] = -k_p[8] - k_p[9] + k_p[10] + k_p[11] + 68'sd536870912;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r = $signed(acc[k][67:30]);
      if (r > 38'sd2147483647) begin
        o[k] = 32'sh7FFFFFFF;
        sat  = 1'b1;
      end else if (r < -38'sd2147483648) begin
        o[k] = 32'sh80000000;
        sat  = 1'b1;
      end else begin
        o[k] = 32'(r);
      end
    end
    if (k_v.zero) begin
      l_data.out_x     = k_v.vec_x;
      l_data.out_y     = k_v.vec_y;
      l_data.out_z     = k_v.vec_z;
      l_data.zero_axis = 1'b1;
      l_data.saturated = 1'b0;
    end else begin
      l_data.out_x     = o[0];
      l_data.out_y     = o[1];
      l_data.out_z     = o[2];
      l_data.zero_axis = 1'b0;
      l_data.saturated = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= l_data;
    end
  end

  // valid bits of the stages held in this module
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld        <= 1'b0;
      b_vld        <= 1'b0;
      c_vld        <= 1'b0;
      d_vld        <= 1'b0;
      e_vld        <= 1'b0;
      f_vld        <= 1'b0;
      g_vld        <= 1'b0;
      h_vld        <= 1'b0;
      i_vld        <= 1'b0;
      j_vld        <= 1'b0;
      k_vld        <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      a_vld        <= item_valid;
      b_vld        <= a_vld;
      c_vld        <= b_vld;
      d_vld        <= c_vld;
      e_vld        <= rt_vld;
      f_vld        <= dv_vld;
      g_vld        <= f_vld;
      h_vld        <= g_vld;
      i_vld        <= h_vld;
      j_vld        <= i_vld;
      k_vld        <= j_vld;
      result_valid <= k_vld;
    end
  end

`ifndef SYNTHESIS
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    dv_vld && !dv_out.side.v.zero |->
      (dv_out.quot[0] <= 31'h40000000) && (dv_out.quot[1] <= 31'h40000000) &&
      (dv_out.quot[2] <= 31'h40000000))
    else $error("unit axis component above one");
  a_len_floor: assert property (@(posedge clk) disable iff (rst)
    e_vld && !e_data.side.v.zero |-> e_data.len >= 32'h40000000)
    else $error("axis length below scaled floor");
  a_zero_nosat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_axis |-> !result.saturated)
    else $error("zero axis transaction flagged saturated");
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule
